// ===== rtl/kte_pkg.sv =====
// Shared types, constants and the key table of the keypad text entry block.
// Used by every module of the block but kte_ram; depends on nothing else.

package kte_pkg;

  // Size of the text store and widths of the item fields.
  localparam int MAX_TEXT = 32;
  localparam int CHAR_W   = 7;
  localparam int GRP_W    = 7;
  localparam int LEN_W    = 6;
  localparam int TXT_AW   = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam logic [LEN_W-1:0] MAX_TEXT_L = LEN_W'(MAX_TEXT);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(32);

  // Keypad groups 2 to 6 are carried as entries 0 to 4.
  localparam int GROUPS    = 5;
  localparam int KEY_TOTAL = 31;

  // Case folding for the letters A to Z.
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'h5A;
  localparam logic [CHAR_W-1:0] LOWER_SHIFT  = 7'h20;

  // Command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_MAX_LENGTH = 1'b0;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_APPEND = 3'd1,
    EV_ERASE  = 3'd2,
    EV_TOGGLE = 3'd3,
    EV_DONE   = 3'd4,
    EV_CANCEL = 3'd5
  } event_e;

  // Command kinds produced by the front end.
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_TYPE,
    CMD_ENTER,
    CMD_CLEAR,
    CMD_ALPHA,
    CMD_SECOND,
    CMD_DELETE
  } cmd_e;

  // One classified frame. For typing, both candidate characters travel so
  // that the back end can pick by its current letter mode.
  typedef struct packed {
    cmd_e              kind;
    logic [CHAR_W-1:0] plain_char;
    logic [CHAR_W-1:0] alpha_char;
  } kte_cmd_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CLOSE
  } back_state_e;

  // One key of the table: group, bit position and its two characters.
  typedef struct packed {
    logic [2:0]        grp;
    logic [2:0]        bitpos;
    logic [CHAR_W-1:0] plain;
    logic [CHAR_W-1:0] alpha;
  } key_entry_t;

  // Scan order of the keys; a zero character means no character.
  localparam key_entry_t KEY_TABLE [KEY_TOTAL] = '{
    '{3'd0, 3'd1, 7'h00, 7'h58}, '{3'd0, 3'd2, 7'h00, 7'h53},
    '{3'd0, 3'd3, 7'h00, 7'h4E}, '{3'd0, 3'd4, 7'h00, 7'h49},
    '{3'd0, 3'd5, 7'h00, 7'h44}, '{3'd0, 3'd6, 7'h00, 7'h41},
    '{3'd1, 3'd0, 7'h30, 7'h20}, '{3'd1, 3'd1, 7'h31, 7'h59},
    '{3'd1, 3'd2, 7'h34, 7'h54}, '{3'd1, 3'd3, 7'h37, 7'h4F},
    '{3'd1, 3'd4, 7'h2C, 7'h4A}, '{3'd1, 3'd5, 7'h00, 7'h45},
    '{3'd1, 3'd6, 7'h00, 7'h42},
    '{3'd2, 3'd0, 7'h2E, 7'h3A}, '{3'd2, 3'd1, 7'h32, 7'h5A},
    '{3'd2, 3'd2, 7'h35, 7'h55}, '{3'd2, 3'd3, 7'h38, 7'h50},
    '{3'd2, 3'd4, 7'h28, 7'h4B}, '{3'd2, 3'd5, 7'h00, 7'h46},
    '{3'd2, 3'd6, 7'h00, 7'h43},
    '{3'd3, 3'd0, 7'h2D, 7'h3F}, '{3'd3, 3'd1, 7'h33, 7'h00},
    '{3'd3, 3'd2, 7'h36, 7'h56}, '{3'd3, 3'd3, 7'h39, 7'h51},
    '{3'd3, 3'd4, 7'h29, 7'h4C}, '{3'd3, 3'd5, 7'h00, 7'h47},
    '{3'd4, 3'd1, 7'h2B, 7'h22}, '{3'd4, 3'd2, 7'h2D, 7'h57},
    '{3'd4, 3'd3, 7'h2A, 7'h52}, '{3'd4, 3'd4, 7'h2F, 7'h4D},
    '{3'd4, 3'd5, 7'h5E, 7'h48}
  };

endpackage

// ===== rtl/kte_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.

module kte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/kte_front.sv =====
// Front end: accepts keypad frames and classifies them into commands.
// Depends on kte_pkg for the command type and the key table.

module kte_front
  import kte_pkg::*;
(
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [GRP_W-1:0]  group2_pressed_i,
  input  logic [GRP_W-1:0]  group3_pressed_i,
  input  logic [GRP_W-1:0]  group4_pressed_i,
  input  logic [GRP_W-1:0]  group5_pressed_i,
  input  logic [GRP_W-1:0]  group6_pressed_i,
  input  logic              enter_pressed_i,
  input  logic              clear_pressed_i,
  input  logic              alpha_pressed_i,
  input  logic              second_pressed_i,
  input  logic              delete_active_i,
  input  logic              full_i,
  output logic              push_o,
  output kte_cmd_t          cmd_o
);

  logic [GRP_W-1:0]  grp [GROUPS];
  logic [CHAR_W-1:0] plain_c;
  logic [CHAR_W-1:0] alpha_c;

  assign grp[0] = group2_pressed_i;
  assign grp[1] = group3_pressed_i;
  assign grp[2] = group4_pressed_i;
  assign grp[3] = group5_pressed_i;
  assign grp[4] = group6_pressed_i;

  // First pressed key with a character, searched separately for each mode.
  // Walking the table backwards lets the earliest key win.
  always_comb begin
    plain_c = '0;
    alpha_c = '0;
    for (int i = KEY_TOTAL - 1; i >= 0; i--) begin
      if (grp[KEY_TABLE[i].grp][KEY_TABLE[i].bitpos]) begin
        if (KEY_TABLE[i].plain != '0) begin
          plain_c = KEY_TABLE[i].plain;
        end
        if (KEY_TABLE[i].alpha != '0) begin
          alpha_c = KEY_TABLE[i].alpha;
        end
      end
    end
  end

  // Command priority: enter, clear, alpha, 2nd, delete, then typing.
  always_comb begin
    cmd_o.plain_char = plain_c;
    cmd_o.alpha_char = alpha_c;
    if (enter_pressed_i) begin
      cmd_o.kind = CMD_ENTER;
    end else if (clear_pressed_i) begin
      cmd_o.kind = CMD_CLEAR;
    end else if (alpha_pressed_i) begin
      cmd_o.kind = CMD_ALPHA;
    end else if (second_pressed_i) begin
      cmd_o.kind = CMD_SECOND;
    end else if (delete_active_i) begin
      cmd_o.kind = CMD_DELETE;
    end else if ((plain_c != '0) || (alpha_c != '0)) begin
      cmd_o.kind = CMD_TYPE;
    end else begin
      cmd_o.kind = CMD_IDLE;
    end
  end

  // An item is taken whenever the queue has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ===== rtl/kte_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on kte_pkg for the command type and the queue depth.

module kte_queue
  import kte_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  kte_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output kte_cmd_t cmd_o
);

  kte_cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/kte_back.sv =====
// Back end: executes commands against the text line and modes, and walks
// the text store for the done emission. Depends on kte_pkg and kte_ram.

module kte_back
  import kte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LEN_W-1:0]  max_length_i,
  input  logic              empty_i,
  input  kte_cmd_t          cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        event_res_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              char_valid_o,
  output logic [LEN_W-1:0]  line_length_o,
  output logic              alpha_mode_o,
  output logic              lower_mode_o,
  output logic              last_o
);

  back_state_e       state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              alpha_q, alpha_d;
  logic              lower_q, lower_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  event_e            ev_q, ev_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic              cv_q, cv_d;
  logic [LEN_W-1:0]  ln_q, ln_d;
  logic              am_q, am_d;
  logic              lm_q, lm_d;
  logic              last_q, last_d;

  logic              out_free;
  logic              ld;
  event_e            ld_ev;
  logic [CHAR_W-1:0] ld_ch;
  logic              ld_cv;
  logic              ld_last;

  logic [LEN_W-1:0]  limit;
  logic [CHAR_W-1:0] sel_c;
  logic [CHAR_W-1:0] typed_c;
  logic [LEN_W-1:0]  idx_nxt;

  logic              wr_en;
  logic              rd_en;
  logic [TXT_AW-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  assign limit    = (max_length_i < MAX_TEXT_L) ? max_length_i : MAX_TEXT_L;
  assign idx_nxt  = idx_q + 1'b1;

  // Character for typing in the current mode, with lower-case folding.
  always_comb begin
    sel_c   = alpha_q ? cmd_i.alpha_char : cmd_i.plain_char;
    typed_c = sel_c;
    if (alpha_q && lower_q && (sel_c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
      typed_c = sel_c + LOWER_SHIFT;
    end
  end

  // Sequencer: one command per pass in idle, or the walk over the text.
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    alpha_d = alpha_q;
    lower_d = lower_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    pop_o   = 1'b0;
    ld      = 1'b0;
    ld_ev   = EV_NONE;
    ld_ch   = '0;
    ld_cv   = 1'b0;
    ld_last = 1'b1;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          ld    = 1'b1;
          case (cmd_i.kind)
            CMD_ENTER: begin
              len_d   = '0;
              alpha_d = 1'b0;
              lower_d = 1'b0;
              cnt_d   = len_q;
              idx_d   = '0;
              ld_ev   = EV_DONE;
              if (len_q != '0) begin
                // Text characters come first; the closing item follows.
                ld      = 1'b0;
                rd_en   = 1'b1;
                state_d = BK_READ;
              end
            end
            CMD_CLEAR: begin
              len_d   = '0;
              alpha_d = 1'b0;
              lower_d = 1'b0;
              ld_ev   = EV_CANCEL;
            end
            CMD_ALPHA: begin
              alpha_d = !alpha_q;
              ld_ev   = EV_TOGGLE;
            end
            CMD_SECOND: begin
              lower_d = !lower_q;
              ld_ev   = EV_TOGGLE;
            end
            CMD_DELETE: begin
              if (len_q != '0) begin
                len_d = len_q - 1'b1;
                ld_ev = EV_ERASE;
              end
            end
            CMD_TYPE: begin
              if ((len_q < limit) && (sel_c != '0)) begin
                wr_en = 1'b1;
                len_d = len_q + 1'b1;
                ld_ev = EV_APPEND;
                ld_ch = typed_c;
                ld_cv = 1'b1;
              end
            end
            default: begin
              ld_ev = EV_NONE;
            end
          endcase
        end
      end
      BK_READ: begin
        // Read data of entry idx_q is waiting in the RAM output register.
        if (out_free) begin
          ld      = 1'b1;
          ld_ev   = EV_DONE;
          ld_ch   = rd_data;
          ld_cv   = 1'b1;
          ld_last = 1'b0;
          idx_d   = idx_nxt;
          if (idx_nxt == cnt_q) begin
            state_d = BK_CLOSE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_nxt[TXT_AW-1:0];
          end
        end
      end
      BK_CLOSE: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_ev   = EV_DONE;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Output register next value; the reported line and modes are after the step.
  always_comb begin
    out_valid_d = out_valid_q;
    ev_d        = ev_q;
    ch_d        = ch_q;
    cv_d        = cv_q;
    ln_d        = ln_q;
    am_d        = am_q;
    lm_d        = lm_q;
    last_d      = last_q;
    if (ld) begin
      out_valid_d = 1'b1;
      ev_d        = ld_ev;
      ch_d        = ld_ch;
      cv_d        = ld_cv;
      ln_d        = len_d;
      am_d        = alpha_d;
      lm_d        = lower_d;
      last_d      = ld_last;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      len_q       <= '0;
      alpha_q     <= 1'b0;
      lower_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      alpha_q     <= alpha_d;
      lower_q     <= lower_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk counters and result payload.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    ev_q   <= ev_d;
    ch_q   <= ch_d;
    cv_q   <= cv_d;
    ln_q   <= ln_d;
    am_q   <= am_d;
    lm_q   <= lm_d;
    last_q <= last_d;
  end

  // Text store.
  kte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (len_q[TXT_AW-1:0]),
    .wr_data_i (typed_c),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign char_code_o   = ch_q;
  assign char_valid_o  = cv_q;
  assign line_length_o = ln_q;
  assign alpha_mode_o  = am_q;
  assign lower_mode_o  = lm_q;
  assign last_o        = last_q;

  // The line never grows past the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= MAX_TEXT_L)
    else $error("text length exceeds the store size");

  // A store write only happens below the effective limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> (len_q < limit))
    else $error("text store written at a full line");

  // The walk index stays below the number of characters to emit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ) |-> (idx_q < cnt_q))
    else $error("done emission walked past the text");

  // Starting the emission leaves the line empty and both modes off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_IDLE) && (state_d == BK_READ)) |=>
      ((len_q == '0) && !alpha_q && !lower_q))
    else $error("line not reset at the start of the done emission");

  // Each emitted text character is followed by more, never a final item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (ev_q == EV_DONE) && cv_q) |-> !last_q)
    else $error("text character of the done emission marked final");

endmodule

// ===== rtl/keypad_text_entry.sv =====
// Keypad text entry: line editor driven by keypad scan frames.
//
// Input channel: one keypad scan frame per item (in_valid_i / in_stall_o).
// A frame is taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: result items (out_valid_o / out_stall_i); last_o marks the
// final item caused by one frame. Every frame causes at least one item.
// A taken frame is written into the command queue; the back end pops it when
// the result register is free, and its results go out through that register.
// Throughput: an ordinary frame takes one idle pass of the back-end sequencer,
// so frames are sustained at one per cycle while the receiver keeps up. Enter
// walks the text store one entry a cycle while the receiver keeps up, through
// the store's registered read port, then emits the closing item; an empty line gives only that item.
// A two-entry command queue lets frames be taken while the back end emits.
// When the receiver stalls, the result register holds its item, the back end
// waits, and once the queue is full in_stall_o rises.
// Reset empties the line, clears both modes and the queue, and sets
// max_length to 32. The text store is not cleared; only written entries
// are ever read. max_length is written over the APB port at byte address 0.
// Depends on kte_pkg, kte_front, kte_queue, kte_back and kte_ram.

module keypad_text_entry
  import kte_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Frame input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [GRP_W-1:0]  group2_pressed_i,
  input  logic [GRP_W-1:0]  group3_pressed_i,
  input  logic [GRP_W-1:0]  group4_pressed_i,
  input  logic [GRP_W-1:0]  group5_pressed_i,
  input  logic [GRP_W-1:0]  group6_pressed_i,
  input  logic              enter_pressed_i,
  input  logic              clear_pressed_i,
  input  logic              alpha_pressed_i,
  input  logic              second_pressed_i,
  input  logic              delete_active_i,
  // Result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        event_res_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              char_valid_o,
  output logic [LEN_W-1:0]  line_length_o,
  output logic              alpha_mode_o,
  output logic              lower_mode_o,
  output logic              last_o
);

  logic [LEN_W-1:0] max_length_q, max_length_d;
  logic             reg_write;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  kte_cmd_t         front_cmd;
  kte_cmd_t         queue_cmd;

  // Configuration register write and read-back.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_LENGTH);

  always_comb begin
    max_length_d = max_length_q;
    if (reg_write) begin
      max_length_d = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LEN_RESET;
    end else begin
      max_length_q <= max_length_d;
    end
  end

  assign prdata = (paddr[2] == REG_MAX_LENGTH) ?
                  {{(APB_DW - LEN_W){1'b0}}, max_length_q} : '0;

  // Frame classification.
  kte_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .group2_pressed_i (group2_pressed_i),
    .group3_pressed_i (group3_pressed_i),
    .group4_pressed_i (group4_pressed_i),
    .group5_pressed_i (group5_pressed_i),
    .group6_pressed_i (group6_pressed_i),
    .enter_pressed_i  (enter_pressed_i),
    .clear_pressed_i  (clear_pressed_i),
    .alpha_pressed_i  (alpha_pressed_i),
    .second_pressed_i (second_pressed_i),
    .delete_active_i  (delete_active_i),
    .full_i           (full),
    .push_o           (push),
    .cmd_o            (front_cmd)
  );

  // Command queue.
  kte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (queue_cmd)
  );

  // Command execution and result output.
  kte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_length_i  (max_length_q),
    .empty_i       (empty),
    .cmd_i         (queue_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .char_code_o   (char_code_o),
    .char_valid_o  (char_valid_o),
    .line_length_o (line_length_o),
    .alpha_mode_o  (alpha_mode_o),
    .lower_mode_o  (lower_mode_o),
    .last_o        (last_o)
  );

endmodule
